FILE: src/knap_pkg.sv
// ----------------------------------------------------------------------------
// knap_pkg
// Shared constants for the 0/1 knapsack solver: default sizes, the capacity
// reset value, the saturation limit of a running value and result kinds.
// ----------------------------------------------------------------------------
package knap_pkg;

  localparam int MAX_ITEMS_DEF = 32;
  localparam int MAX_CAP_DEF   = 255;

  localparam int WGT_W = 8;
  localparam int VAL_W = 16;
  localparam int AMT_W = 21;
  localparam int NUM_W = 6;

  localparam logic [WGT_W-1:0] CAP_RESET  = 8'd255;
  localparam logic [AMT_W-1:0] AMOUNT_MAX = 21'h1FFFFF;

  localparam logic KIND_TOTAL = 1'b0;
  localparam logic KIND_ITEM  = 1'b1;

endpackage

FILE: src/knapsack_dp_with_traceback.sv
// ----------------------------------------------------------------------------
// knapsack_dp_with_traceback
// 0/1 knapsack solver. A best-value row and the per-item take bits live in
// synchronous memories; each item sweeps the row once, then a traceback walks
// the take bits from the last item to the first.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: capacity_wr_en / capacity_wr_data write the capacity while
//   the block is idle. Values above MAX_CAP are clamped to MAX_CAP.
//   Item channel: item_valid / item_stall carry weight, value and last_item.
//   Each item sweeps capacities MAX_CAP down to 1 through a two-read,
//   one-write row memory, one entry per cycle; item_stall stays high until
//   the sweep is done. An item beyond MAX_ITEMS is dropped.
//   Result channel: result_valid / result_stall. After the last item the
//   total comes out, then each chosen item, last one flagged final_result.
//   Solve: S_SOLVE, S_TOTAL, then S_TB_RD and S_TB_EVAL per item examined,
//   then S_TB_END; a result is held back until the next is known so its
//   final flag is correct. After the run the row is cleared, during which
//   item_stall is high. The output register holds a beat while result_stall
//   is high; the traceback waits for it, the clear does not.
//   Reset (rst, synchronous): capacity = 255, item count 0, no result pending,
//   then the same row clear before the first item is taken.
// ----------------------------------------------------------------------------
module knapsack_dp_with_traceback #(
  parameter int MAX_ITEMS = knap_pkg::MAX_ITEMS_DEF,
  parameter int MAX_CAP   = knap_pkg::MAX_CAP_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         capacity_wr_en,
  input  logic [knap_pkg::WGT_W-1:0]   capacity_wr_data,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [knap_pkg::WGT_W-1:0]   item_weight,
  input  logic [knap_pkg::VAL_W-1:0]   item_value,
  input  logic                         last_item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         result_kind,
  output logic [knap_pkg::NUM_W-1:0]   item_number,
  output logic [knap_pkg::WGT_W-1:0]   chosen_weight,
  output logic [knap_pkg::AMT_W-1:0]   amount,
  output logic                         final_result
);

  localparam int CW    = $clog2(MAX_CAP + 1);
  localparam int CMPW  = (CW > knap_pkg::WGT_W) ? CW : knap_pkg::WGT_W;
  localparam int IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int NW    = $clog2(MAX_ITEMS + 1);
  localparam int TK_DEPTH = 2 ** (IW + CW);
  localparam int AW    = knap_pkg::AMT_W;
  localparam int NMW   = knap_pkg::NUM_W;

  localparam logic [CW-1:0]   CAP_TOP   = CW'(MAX_CAP);
  localparam logic [CMPW-1:0] CAP_TOP_X = CMPW'(MAX_CAP);
  localparam logic [NW-1:0]   ITEMS_TOP = NW'(MAX_ITEMS);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UPD      = 4'd1;
  localparam logic [3:0] S_UPD_TAIL = 4'd2;
  localparam logic [3:0] S_SOLVE    = 4'd3;
  localparam logic [3:0] S_TOTAL    = 4'd4;
  localparam logic [3:0] S_TB_RD    = 4'd5;
  localparam logic [3:0] S_TB_EVAL  = 4'd6;
  localparam logic [3:0] S_TB_END   = 4'd7;
  localparam logic [3:0] S_CLEAR    = 4'd8;

  // memories
  logic [AW-1:0]             bm [0:MAX_CAP];
  logic                      tk [0:TK_DEPTH-1];
  logic [knap_pkg::WGT_W-1:0] sw [0:MAX_ITEMS-1];
  logic [knap_pkg::VAL_W-1:0] sv [0:MAX_ITEMS-1];

  logic [AW-1:0]              bm_qa, bm_qb;
  logic                       tk_q;
  logic [knap_pkg::WGT_W-1:0] sw_q;
  logic [knap_pkg::VAL_W-1:0] sv_q;

  logic                  bm_re, bm_we;
  logic [CW-1:0]         bm_ra, bm_rb, bm_wa;
  logic [AW-1:0]         bm_wd;
  logic                  tb_re;
  logic [IW-1:0]         tb_idx;

  // control
  logic [3:0]                 state;
  logic [knap_pkg::WGT_W-1:0] capacity;
  logic [NW-1:0]              items_loaded;
  logic [knap_pkg::WGT_W-1:0] cur_w;
  logic [knap_pkg::VAL_W-1:0] cur_v;
  logic [IW-1:0]              cur_idx;
  logic [CW-1:0]              cur_cap;
  logic                       cur_last;
  logic [CW-1:0]              upd_j;
  logic                       s2_v;
  logic                       s2_ok;
  logic [CW-1:0]              s2_j;
  logic [NW-1:0]              tb_i;
  logic [CW-1:0]              tb_j;
  logic [CW-1:0]              clr_j;

  logic                       pend_kind;
  logic [NW-1:0]              pend_num;
  logic [knap_pkg::WGT_W-1:0] pend_w;
  logic [AW-1:0]              pend_amt;

  // combinational helpers
  logic                  item_acc;
  logic                  out_free;
  logic                  out_load;
  logic [CMPW-1:0]       cap_x, cap_used, upd_j_x, w_x, tb_j_x, sw_x;
  logic [AW:0]           cand_sum;
  logic [AW-1:0]         cand;
  logic                  s2_take;

  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign out_load   = out_free && (((state == S_TB_EVAL) && tk_q) || (state == S_TB_END));

  assign cap_x    = CMPW'(capacity);
  assign cap_used = (cap_x > CAP_TOP_X) ? CAP_TOP_X : cap_x;
  assign upd_j_x  = CMPW'(upd_j);
  assign w_x      = CMPW'(cur_w);
  assign tb_j_x   = CMPW'(tb_j);
  assign sw_x     = CMPW'(sw_q);

  assign cand_sum = {1'b0, bm_qb} + (AW + 1)'(cur_v);
  assign cand     = (cand_sum > (AW + 1)'(knap_pkg::AMOUNT_MAX)) ?
                    knap_pkg::AMOUNT_MAX : cand_sum[AW-1:0];
  assign s2_take  = s2_v && s2_ok && (cand > bm_qa);

  always_comb begin
    bm_re = (state == S_UPD) || (state == S_SOLVE);
    bm_ra = (state == S_SOLVE) ? cur_cap : upd_j;
    bm_rb = CW'(upd_j_x - w_x);
    bm_we = s2_take || (state == S_CLEAR);
    bm_wa = (state == S_CLEAR) ? clr_j : s2_j;
    bm_wd = (state == S_CLEAR) ? '0 : cand;
    tb_re = (state == S_TB_RD) && (tb_i != '0) && (tb_j != '0);
    tb_idx = IW'(tb_i - 1'b1);
  end

  // best-value row: two reads, one write
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm[bm_wa] <= bm_wd;
    end
    if (bm_re) begin
      bm_qa <= bm[bm_ra];
      bm_qb <= bm[bm_rb];
    end
  end

  // take bits
  always_ff @(posedge clk) begin
    if (s2_v) begin
      tk[{cur_idx, s2_j}] <= s2_take;
    end
    if (tb_re) begin
      tk_q <= tk[{tb_idx, tb_j}];
    end
  end

  // item store
  always_ff @(posedge clk) begin
    if (item_acc && (items_loaded < ITEMS_TOP)) begin
      sw[items_loaded[IW-1:0]] <= item_weight;
      sv[items_loaded[IW-1:0]] <= item_value;
    end
    if (tb_re) begin
      sw_q <= sw[tb_idx];
      sv_q <= sv[tb_idx];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_acc) begin
      cur_w    <= item_weight;
      cur_v    <= item_value;
      cur_idx  <= items_loaded[IW-1:0];
      cur_cap  <= CW'(cap_used);
      cur_last <= last_item;
    end
    s2_j  <= upd_j;
    s2_ok <= (upd_j_x <= CMPW'(cur_cap)) && (w_x <= upd_j_x);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      capacity     <= knap_pkg::CAP_RESET;
      items_loaded <= '0;
      clr_j        <= CAP_TOP;
      upd_j        <= CAP_TOP;
      s2_v         <= 1'b0;
      result_valid <= 1'b0;
      tb_i         <= '0;
      tb_j         <= '0;
    end else begin
      if (capacity_wr_en) begin
        capacity <= capacity_wr_data;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      s2_v <= (state == S_UPD);

      case (state)
        S_IDLE: begin
          if (item_acc) begin
            if (items_loaded < ITEMS_TOP) begin
              items_loaded <= items_loaded + 1'b1;
              upd_j        <= CAP_TOP;
              state        <= S_UPD;
            end else if (last_item) begin
              state <= S_SOLVE;
            end
          end
        end
        S_UPD: begin
          if (upd_j == CW'(1)) begin
            state <= S_UPD_TAIL;
          end else begin
            upd_j <= upd_j - 1'b1;
          end
        end
        S_UPD_TAIL: begin
          state <= cur_last ? S_SOLVE : S_IDLE;
        end
        S_SOLVE: begin
          state <= S_TOTAL;
        end
        S_TOTAL: begin
          pend_kind <= knap_pkg::KIND_TOTAL;
          pend_num  <= '0;
          pend_w    <= '0;
          pend_amt  <= bm_qa;
          tb_i      <= items_loaded;
          tb_j      <= cur_cap;
          state     <= S_TB_RD;
        end
        S_TB_RD: begin
          state <= tb_re ? S_TB_EVAL : S_TB_END;
        end
        S_TB_EVAL: begin
          if (!tk_q) begin
            tb_i  <= tb_i - 1'b1;
            state <= S_TB_RD;
          end else if (out_free) begin
            result_kind   <= pend_kind;
            item_number   <= NMW'(pend_num);
            chosen_weight <= pend_w;
            amount        <= pend_amt;
            final_result  <= 1'b0;
            pend_kind     <= knap_pkg::KIND_ITEM;
            pend_num      <= tb_i;
            pend_w        <= sw_q;
            pend_amt      <= AW'(sv_q);
            tb_j          <= (sw_x <= tb_j_x) ? CW'(tb_j_x - sw_x) : '0;
            tb_i          <= tb_i - 1'b1;
            state         <= S_TB_RD;
          end
        end
        S_TB_END: begin
          if (out_free) begin
            result_kind   <= pend_kind;
            item_number   <= NMW'(pend_num);
            chosen_weight <= pend_w;
            amount        <= pend_amt;
            final_result  <= 1'b1;
            items_loaded  <= '0;
            clr_j         <= CAP_TOP;
            state         <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (clr_j == '0) begin
            state <= S_IDLE;
          end else begin
            clr_j <= clr_j - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: test/knap_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// knap_checker
// Watches the config port and both channels of the knapsack solver. Keeps its
// own best-value row, take bits and item store, solves each set when its last
// item is taken and compares every result beat with the oldest one due.
// ----------------------------------------------------------------------------
module knap_checker #(
  parameter int MAX_ITEMS = knap_pkg::MAX_ITEMS_DEF,
  parameter int MAX_CAP   = knap_pkg::MAX_CAP_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       capacity_wr_en,
  input  logic [knap_pkg::WGT_W-1:0] capacity_wr_data,
  input  logic                       item_valid,
  input  logic                       item_stall,
  input  logic [knap_pkg::WGT_W-1:0] item_weight,
  input  logic [knap_pkg::VAL_W-1:0] item_value,
  input  logic                       last_item,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  logic                       result_kind,
  input  logic [knap_pkg::NUM_W-1:0] item_number,
  input  logic [knap_pkg::WGT_W-1:0] chosen_weight,
  input  logic [knap_pkg::AMT_W-1:0] amount,
  input  logic                       final_result,
  output int                         mismatches,
  output int                         pending,
  output int                         beats_checked
);

  localparam int WW = knap_pkg::WGT_W;
  localparam int VW = knap_pkg::VAL_W;
  localparam int NW = knap_pkg::NUM_W;
  localparam int AW = knap_pkg::AMT_W;

  typedef struct packed {
    logic          kind;
    logic [NW-1:0] num;
    logic [WW-1:0] wgt;
    logic [AW-1:0] amt;
    logic          fin;
  } sol_beat_t;

  logic [AW-1:0] best_val [0:MAX_CAP];
  bit            took     [0:MAX_ITEMS-1][0:MAX_CAP];
  logic [WW-1:0] kept_wgt [0:MAX_ITEMS-1];
  logic [VW-1:0] kept_val [0:MAX_ITEMS-1];
  int            n_loaded;
  logic [WW-1:0] cap_reg;
  sol_beat_t     solution_q [$];
  sol_beat_t     seen_beat;
  sol_beat_t     due_beat;

  function automatic int cap_in_force();
    return (int'(cap_reg) > MAX_CAP) ? MAX_CAP : int'(cap_reg);
  endfunction

  function automatic string beat_text(sol_beat_t b);
    return $sformatf("kind=%0d num=%0d wgt=%0d amt=%0d fin=%0d",
                     b.kind, b.num, b.wgt, b.amt, b.fin);
  endfunction

  function automatic void flag(string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch: %s", $time, msg);
  endfunction

  // one sweep of the row, high capacity to low
  task automatic load_item(input logic [WW-1:0] w, input logic [VW-1:0] v);
    int          cap;
    int          j;
    logic [AW:0] cand;
    bit          tk;
    cap = cap_in_force();
    kept_wgt[n_loaded] = w;
    kept_val[n_loaded] = v;
    for (j = MAX_CAP; j >= 1; j--) begin
      tk = 1'b0;
      if (j <= cap && int'(w) <= j) begin
        cand = {1'b0, best_val[j - int'(w)]} + v;
        if (cand > {1'b0, knap_pkg::AMOUNT_MAX})
          cand = {1'b0, knap_pkg::AMOUNT_MAX};
        if (cand[AW-1:0] > best_val[j]) begin
          best_val[j] = cand[AW-1:0];
          tk = 1'b1;
        end
      end
      took[n_loaded][j] = tk;
    end
    took[n_loaded][0] = 1'b0;
    n_loaded++;
  endtask

  // total first, then the traceback; final flag goes on the last beat only
  task automatic solve_set();
    int        rem;
    int        i;
    int        k;
    sol_beat_t b;
    rem = cap_in_force();
    b = '{kind: knap_pkg::KIND_TOTAL, num: '0, wgt: '0, amt: best_val[rem], fin: 1'b1};
    for (i = n_loaded; i >= 1 && rem != 0; i--) begin
      if (took[i-1][rem]) begin
        b.fin = 1'b0;
        solution_q.push_back(b);
        b = '{kind: knap_pkg::KIND_ITEM, num: NW'(i), wgt: kept_wgt[i-1],
              amt: AW'(kept_val[i-1]), fin: 1'b1};
        rem = (int'(kept_wgt[i-1]) <= rem) ? rem - int'(kept_wgt[i-1]) : 0;
      end
    end
    solution_q.push_back(b);
    for (k = 0; k <= MAX_CAP; k++)
      best_val[k] = '0;
    n_loaded = 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cap_reg = knap_pkg::CAP_RESET;
      n_loaded = 0;
      for (int k = 0; k <= MAX_CAP; k++)
        best_val[k] = '0;
      solution_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        seen_beat = '{kind: result_kind, num: item_number, wgt: chosen_weight,
                      amt: amount, fin: final_result};
        beats_checked++;
        if (solution_q.size() == 0) begin
          flag($sformatf("result beat with nothing due: %s", beat_text(seen_beat)));
        end else begin
          due_beat = solution_q.pop_front();
          if (seen_beat !== due_beat)
            flag($sformatf("expected %s, got %s", beat_text(due_beat),
                           beat_text(seen_beat)));
        end
      end
      if (item_valid && !item_stall) begin
        if (n_loaded < MAX_ITEMS)
          load_item(item_weight, item_value);
        if (last_item)
          solve_set();
      end
      if (capacity_wr_en)
        cap_reg = capacity_wr_data;
    end
    pending = solution_q.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives item sets and capacity writes into the knapsack solver with random
// gaps and result stalls, a long result hold-off and full item stores; the
// checker alongside predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SETTLE   = knap_pkg::MAX_CAP_DEF + 40;
  localparam int HOLD_SET = 9;

  logic                       clk              = 1'b0;
  logic                       rst              = 1'b1;
  logic                       capacity_wr_en   = 1'b0;
  logic [knap_pkg::WGT_W-1:0] capacity_wr_data = '0;
  logic                       item_valid       = 1'b0;
  logic [knap_pkg::WGT_W-1:0] item_weight      = '0;
  logic [knap_pkg::VAL_W-1:0] item_value       = '0;
  logic                       last_item        = 1'b0;
  logic                       result_stall     = 1'b0;
  logic                       item_stall;
  logic                       result_valid;
  logic                       result_kind;
  logic [knap_pkg::NUM_W-1:0] item_number;
  logic [knap_pkg::WGT_W-1:0] chosen_weight;
  logic [knap_pkg::AMT_W-1:0] amount;
  logic                       final_result;

  int mismatches;
  int pending;
  int beats_checked;
  int items_sent;
  int sets_sent;
  int cfg_writes;
  bit calm;
  int rx_hold;

  knapsack_dp_with_traceback dut (
    .clk              (clk),
    .rst              (rst),
    .capacity_wr_en   (capacity_wr_en),
    .capacity_wr_data (capacity_wr_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .item_weight      (item_weight),
    .item_value       (item_value),
    .last_item        (last_item),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result_kind      (result_kind),
    .item_number      (item_number),
    .chosen_weight    (chosen_weight),
    .amount           (amount),
    .final_result     (final_result)
  );

  knap_checker chk (
    .clk              (clk),
    .rst              (rst),
    .capacity_wr_en   (capacity_wr_en),
    .capacity_wr_data (capacity_wr_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .item_weight      (item_weight),
    .item_value       (item_value),
    .last_item        (last_item),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result_kind      (result_kind),
    .item_number      (item_number),
    .chosen_weight    (chosen_weight),
    .amount           (amount),
    .final_result     (final_result),
    .mismatches       (mismatches),
    .pending          (pending),
    .beats_checked    (beats_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d result beats outstanding", pending);
    $display("status: fail");
    $finish;
  end

  // result side: random stall per beat, plus a long hold-off on request
  initial begin : result_side
    int n;
    forever begin
      if (rx_hold > 0) begin
        result_stall <= 1'b1;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      n = calm ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid && rx_hold == 0) @(posedge clk);
    end
  end

  task automatic send_item(input logic [knap_pkg::WGT_W-1:0] w,
                           input logic [knap_pkg::VAL_W-1:0] v,
                           input logic closes);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    item_weight <= w;
    item_value  <= v;
    last_item   <= closes;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (closes)
      sets_sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [knap_pkg::WGT_W-1:0] c);
    item_valid <= 1'b0;
    wait_drained();
    capacity_wr_en   <= 1'b1;
    capacity_wr_data <= c;
    @(posedge clk);
    capacity_wr_en <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [knap_pkg::WGT_W-1:0] pick_capacity();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [knap_pkg::WGT_W-1:0] rand_weight();
    if ($urandom_range(0, 3) == 0)
      return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 40));
  endfunction

  function automatic logic [knap_pkg::VAL_W-1:0] rand_value();
    if ($urandom_range(0, 3) == 0)
      return 16'($urandom_range(0, 15));
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin : stimulus
    int  set_no;
    int  size;
    int  k;
    bit  heavy;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset capacity, zero weight, extreme fields
    send_item(8'd0, 16'hFFFF, 1'b0);
    send_item(8'd255, 16'hFFFF, 1'b1);
    // nothing worth taking
    send_item(8'd255, 16'd0, 1'b1);
    // capacity zero
    write_capacity(8'd0);
    send_item(8'd10, 16'd100, 1'b0);
    send_item(8'd0, 16'd5, 1'b1);
    write_capacity(8'd1);
    send_item(8'd1, 16'h8000, 1'b0);
    send_item(8'd0, 16'h7FFF, 1'b0);
    send_item(8'd1, 16'hFFFF, 1'b1);
    // capacity moves inside a set
    write_capacity(8'd100);
    send_item(8'd50, 16'd1000, 1'b0);
    write_capacity(8'd30);
    send_item(8'd20, 16'd500, 1'b0);
    write_capacity(8'd200);
    send_item(8'd150, 16'd3000, 1'b0);
    send_item(8'd120, 16'd2500, 1'b1);
    write_capacity(8'd255);
    send_item(8'd200, 16'd7, 1'b0);
    send_item(8'd56, 16'd3, 1'b0);
    send_item(8'd255, 16'd9, 1'b0);
    send_item(8'd0, 16'd0, 1'b1);

    set_no = 0;
    while (items_sent < 210) begin
      calm = ($urandom_range(0, 4) == 0);
      if (set_no == 0 || (set_no != HOLD_SET + 1 && $urandom_range(0, 3) == 0))
        write_capacity(pick_capacity());
      if (set_no == 4 || set_no == 22)
        size = $urandom_range(33, 35);
      else if (set_no == HOLD_SET)
        size = 3;
      else
        size = $urandom_range(1, 8);
      // results of this set sit behind a long stall while the next set queues
      if (set_no == HOLD_SET)
        rx_hold = 3000;
      heavy = (set_no == 22);
      for (k = 0; k < size; k++) begin
        if (k > 0 && k == size / 2 && set_no != HOLD_SET + 1 && $urandom_range(0, 7) == 0)
          write_capacity(pick_capacity());
        if (heavy)
          send_item(8'd0, 16'hFFFF, k == size - 1);
        else
          send_item(rand_weight(), rand_value(), k == size - 1);
      end
      set_no++;
    end

    item_valid <= 1'b0;
    wait_drained();
    $display("%0d items in %0d sets, %0d capacity writes, %0d result beats checked",
             items_sent, sets_sent, cfg_writes, beats_checked);
    $display("%0d mismatches, %0d beats still due", mismatches, pending);
    if (mismatches == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
